/* src/lafr_pkg.sv */
`timescale 1ns / 1ps

package lafr_pkg;

	localparam int BYTE_W   = 8;
	localparam int CFG_IDX_W = 8;

	localparam logic [BYTE_W-1:0] START_CODE_RST = 8'h02;
	localparam logic [BYTE_W-1:0] ACK_CODE_RST   = 8'h06;

	localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE   = 8'd1;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BADSTART = 3'd1,
		ST_ZEROLEN  = 3'd2,
		ST_TIMEOUT  = 3'd3,
		ST_CHECKSUM = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_LEN   = 4'b0010,
		PH_DATA  = 4'b0100,
		PH_CHECK = 4'b1000
	} phase_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] byte_index;
		status_t           status;
		logic [BYTE_W-1:0] frame_length;
		logic              send_ack;
		logic [BYTE_W-1:0] ack_byte;
	} result_t;

	// handshake between the frame engine and the result register
	typedef struct packed {
		logic load;
		logic advance;
	} pipe_ctl_t;

endpackage

/* src/lafr_if.sv */
`timescale 1ns / 1ps

interface lafr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       timed_out;

	modport source (output valid, rx_byte, timed_out, input ready);
	modport sink   (input valid, rx_byte, timed_out, output ready);
endinterface

interface lafr_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic [7:0] byte_index;
	logic [2:0] status;
	logic [7:0] frame_length;
	logic       send_ack;
	logic [7:0] ack_byte;

	modport source (output valid, kind, data_byte, byte_index, status, frame_length,
		send_ack, ack_byte, input ready);
	modport sink   (input valid, kind, data_byte, byte_index, status, frame_length,
		send_ack, ack_byte, output ready);
endinterface

interface lafr_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* src/lrc_answer_frame_receiver.sv */
`timescale 1ns / 1ps
// A received byte passes the input register, then the result register, to reach res;
// it is held in the input register while the result register is still held.
// Throughput: one received byte per cycle unless a held result stalls; input register
// and result register each advance once the result register is empty or being taken.
// Reset (arst_n low): frame state back to waiting for start, both stages empty,
// start_code = 2 and acknowledge_code = 6. No clearing pass.

module lrc_answer_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	lafr_in_if.sink     rx,
	lafr_out_if.source  res,
	lafr_cfg_if.sink    cfg
);

	logic [lafr_pkg::BYTE_W-1:0] start_code;
	logic [lafr_pkg::BYTE_W-1:0] acknowledge_code;
	logic                        advance;
	lafr_pkg::pipe_ctl_t         ctl;
	lafr_pkg::result_t           result;

	lafr_cfg_regs u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.start_code       (start_code),
		.acknowledge_code (acknowledge_code)
	);

	lafr_frame_engine u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.rx               (rx),
		.start_code       (start_code),
		.acknowledge_code (acknowledge_code),
		.advance          (advance),
		.ctl              (ctl),
		.result           (result)
	);

	lafr_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.result  (result),
		.advance (advance),
		.res     (res)
	);

	// input only stalls behind a held result
	a_rx_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (res.valid && !res.ready))
		else $error("input stalled without output backpressure");

	a_ok_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == lafr_pkg::KIND_STATUS && res.status == lafr_pkg::ST_OK)
		|-> (res.send_ack && res.frame_length != '0))
		else $error("ok status without acknowledge or length");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == lafr_pkg::KIND_DATA)
		|-> (!res.send_ack && res.status == lafr_pkg::ST_OK && res.frame_length == '0))
		else $error("data request carries status fields");

endmodule

/* src/lafr_cfg_regs.sv */
`timescale 1ns / 1ps

module lafr_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	lafr_cfg_if.sink                      cfg,
	output logic [lafr_pkg::BYTE_W-1:0]   start_code,
	output logic [lafr_pkg::BYTE_W-1:0]   acknowledge_code
);

	logic [lafr_pkg::BYTE_W-1:0] start_code_q;
	logic [lafr_pkg::BYTE_W-1:0] ack_code_q;

	assign cfg.ready = 1'b1;

	// unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= lafr_pkg::START_CODE_RST;
			ack_code_q   <= lafr_pkg::ACK_CODE_RST;
		end else if (cfg.valid) begin
			if (cfg.index == lafr_pkg::REG_START_CODE) begin
				start_code_q <= cfg.data;
			end
			if (cfg.index == lafr_pkg::REG_ACK_CODE) begin
				ack_code_q <= cfg.data;
			end
		end
	end

	assign start_code       = start_code_q;
	assign acknowledge_code = ack_code_q;

endmodule

/* src/lafr_frame_engine.sv */
`timescale 1ns / 1ps

module lafr_frame_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	lafr_in_if.sink                       rx,
	input  logic [lafr_pkg::BYTE_W-1:0]   start_code,
	input  logic [lafr_pkg::BYTE_W-1:0]   acknowledge_code,
	input  logic                          advance,
	output lafr_pkg::pipe_ctl_t           ctl,
	output lafr_pkg::result_t             result
);

	logic                        valid_s1;
	logic [lafr_pkg::BYTE_W-1:0] byte_s1;
	logic                        tmo_s1;

	lafr_pkg::phase_t            phase_q,  phase_d;
	logic [lafr_pkg::BYTE_W-1:0] left_q,   left_d;
	logic [lafr_pkg::BYTE_W-1:0] check_q,  check_d;
	logic [lafr_pkg::BYTE_W-1:0] length_q, length_d;

	logic fire;
	logic res_valid;
	logic take_check;

	assign rx.ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
			tmo_s1  <= rx.timed_out;
		end
	end

	// a data phase with nothing left treats the byte as the check byte
	assign take_check = (phase_q == lafr_pkg::PH_CHECK) ||
		((phase_q == lafr_pkg::PH_DATA) && (left_q == '0));

	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		check_d   = check_q;
		length_d  = length_q;
		res_valid = 1'b0;
		result    = '0;
		if (tmo_s1) begin
			phase_d       = lafr_pkg::PH_START;
			res_valid     = 1'b1;
			result.kind   = lafr_pkg::KIND_STATUS;
			result.status = lafr_pkg::ST_TIMEOUT;
		end else if (take_check) begin
			phase_d     = lafr_pkg::PH_START;
			res_valid   = 1'b1;
			result.kind = lafr_pkg::KIND_STATUS;
			if (byte_s1 == check_q) begin
				result.status       = lafr_pkg::ST_OK;
				result.frame_length = length_q;
				result.send_ack     = 1'b1;
				result.ack_byte     = acknowledge_code;
			end else begin
				result.status = lafr_pkg::ST_CHECKSUM;
			end
		end else begin
			case (phase_q)
				lafr_pkg::PH_START: begin
					if (byte_s1 != start_code) begin
						res_valid     = 1'b1;
						result.kind   = lafr_pkg::KIND_STATUS;
						result.status = lafr_pkg::ST_BADSTART;
					end else begin
						phase_d = lafr_pkg::PH_LEN;
					end
				end
				lafr_pkg::PH_LEN: begin
					if (byte_s1 == '0) begin
						phase_d       = lafr_pkg::PH_START;
						res_valid     = 1'b1;
						result.kind   = lafr_pkg::KIND_STATUS;
						result.status = lafr_pkg::ST_ZEROLEN;
					end else begin
						phase_d  = lafr_pkg::PH_DATA;
						left_d   = byte_s1;
						check_d  = byte_s1;
						length_d = byte_s1;
					end
				end
				lafr_pkg::PH_DATA: begin
					res_valid         = 1'b1;
					result.kind       = lafr_pkg::KIND_DATA;
					result.data_byte  = byte_s1;
					result.byte_index = length_q - left_q;
					check_d           = check_q ^ byte_s1;
					left_d            = left_q - 1'b1;
					if (left_q == 8'd1) begin
						phase_d = lafr_pkg::PH_CHECK;
					end
				end
				default: begin
					phase_d = lafr_pkg::PH_START;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lafr_pkg::PH_START;
			left_q   <= '0;
			check_q  <= '0;
			length_q <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			left_q   <= left_d;
			check_q  <= check_d;
			length_q <= length_d;
		end
	end

	assign ctl.load    = fire && res_valid;
	assign ctl.advance = advance;

endmodule

/* src/lafr_out_reg.sv */
`timescale 1ns / 1ps

module lafr_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  lafr_pkg::pipe_ctl_t ctl,
	input  lafr_pkg::result_t   result,
	output logic                advance,
	lafr_out_if.source          res
);

	logic              valid_q;
	lafr_pkg::result_t result_q;

	// the register frees up when empty or when the consumer takes the request
	assign advance = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.advance) begin
			valid_q <= ctl.load;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			result_q <= result;
		end
	end

	assign res.valid        = valid_q;
	assign res.kind         = result_q.kind;
	assign res.data_byte    = result_q.data_byte;
	assign res.byte_index   = result_q.byte_index;
	assign res.status       = result_q.status;
	assign res.frame_length = result_q.frame_length;
	assign res.send_ack     = result_q.send_ack;
	assign res.ack_byte     = result_q.ack_byte;

endmodule
